// ----- hdl/rcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants of the remote command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

   localparam logic [7:0] HEADER_BYTE  = 8'hBB;
   localparam logic [7:0] TRAILER_BYTE = 8'hCC;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // input word kinds
   localparam logic CMD_RX_BYTE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IDLE_TIMEOUT = 3'd0,
      REG_MAX_LENGTH   = 3'd1,
      REG_CODE_SPEED   = 3'd2,
      REG_CODE_ANGLE   = 3'd3,
      REG_CODE_POS     = 3'd4,
      REG_CODE_STOP    = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd50;
   localparam logic [5:0]  RST_MAX_LENGTH   = 6'd32;
   localparam logic [7:0]  RST_CODE_SPEED   = 8'd1;
   localparam logic [7:0]  RST_CODE_ANGLE   = 8'd2;
   localparam logic [7:0]  RST_CODE_POS     = 8'd3;
   localparam logic [7:0]  RST_CODE_STOP    = 8'd4;

   typedef struct packed {
      logic [15:0] idle_timeout;
      logic [5:0]  max_length;
      logic [7:0]  code_speed;
      logic [7:0]  code_angle;
      logic [7:0]  code_pos;
      logic [7:0]  code_stop;
   } cfg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0]         frame_command;
      logic signed [15:0] speed_goal;
      logic signed [15:0] angle_target;
      logic signed [15:0] position_target;
      logic               ack;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/rcfp_if.sv -----
// ----------------------------------------------------------------------------
// rcfp channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface rcfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         frame_command;
   logic signed [15:0] speed_goal;
   logic signed [15:0] angle_target;
   logic signed [15:0] position_target;
   logic               ack;

   modport source (output valid, output frame_command, output speed_goal,
                   output angle_target, output position_target, output ack,
                   input ready);
   modport sink   (input valid, input frame_command, input speed_goal,
                   input angle_target, input position_target, input ack,
                   output ready);
endinterface

interface rcfp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rcfp_pkg::CSR_INDEX_W-1:0]   reg_index;
   logic [rcfp_pkg::CSR_DATA_W-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rcfp_csr.sv -----
// ----------------------------------------------------------------------------
// rcfp_csr
// Configuration register file: idle timeout, length limit and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   rcfp_csr_if.sink           csr_chan,
   output rcfp_pkg::cfg_type  cfg
);

   rcfp_pkg::cfg_type cfg_ff;
   rcfp_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (rcfp_pkg::csr_index_type'(csr_chan.reg_index))
            rcfp_pkg::REG_IDLE_TIMEOUT: cfg_in.idle_timeout = csr_chan.wr_data;
            rcfp_pkg::REG_MAX_LENGTH:   cfg_in.max_length   = csr_chan.wr_data[5:0];
            rcfp_pkg::REG_CODE_SPEED:   cfg_in.code_speed   = csr_chan.wr_data[7:0];
            rcfp_pkg::REG_CODE_ANGLE:   cfg_in.code_angle   = csr_chan.wr_data[7:0];
            rcfp_pkg::REG_CODE_POS:     cfg_in.code_pos     = csr_chan.wr_data[7:0];
            rcfp_pkg::REG_CODE_STOP:    cfg_in.code_stop    = csr_chan.wr_data[7:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout <= rcfp_pkg::RST_IDLE_TIMEOUT;
         cfg_ff.max_length   <= rcfp_pkg::RST_MAX_LENGTH;
         cfg_ff.code_speed   <= rcfp_pkg::RST_CODE_SPEED;
         cfg_ff.code_angle   <= rcfp_pkg::RST_CODE_ANGLE;
         cfg_ff.code_pos     <= rcfp_pkg::RST_CODE_POS;
         cfg_ff.code_stop    <= rcfp_pkg::RST_CODE_STOP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rcfp_engine.sv -----
// ----------------------------------------------------------------------------
// rcfp_engine
// Frame parse state and target registers, updated once per consumed word.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_engine #(
   parameter int BUFFER_BYTES = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  rcfp_pkg::cfg_type     cfg,
   input  rcfp_pkg::item_type    item,
   input  wire logic             advance,
   output logic                  fire,
   output rcfp_pkg::result_type  result
);

   localparam int POS_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES);
   localparam logic [POS_W-1:0] POS_CMD   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LOW   = POS_W'(4);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic             latched_ff, latched_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [15:0]      speed_ff, speed_in;
   logic [15:0]      angle_ff, angle_in;
   logic [15:0]      posn_ff, posn_in;

   logic [7:0]       cur_len;
   logic [7:0]       rx;
   logic             len_bad;
   logic             done;

   assign rx = item.rx_byte;

   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      latched_in = latched_ff;
      cmd_in     = cmd_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      ticks_in   = ticks_ff;
      speed_in   = speed_ff;
      angle_in   = angle_ff;
      posn_in    = posn_ff;
      cur_len    = len_ff;
      len_bad    = 1'b0;
      done       = 1'b0;
      fire       = 1'b0;

      if (item.command == rcfp_pkg::CMD_TICK) begin
         if (ticks_ff != 16'hFFFF) begin
            ticks_in = ticks_ff + 16'd1;
         end
         if (pos_ff != '0 && ticks_in > cfg.idle_timeout) begin
            done = 1'b1;
         end
      end else if (pos_ff >= POS_LIMIT) begin
         done = 1'b1;  // overflow, word discarded
      end else if (pos_ff == '0) begin
         // hunting for header
         if (rx == rcfp_pkg::HEADER_BYTE) begin
            ticks_in = '0;
            pos_in   = POS_W'(1);
            high_in  = '0;
            low_in   = '0;
         end
      end else begin
         if (!latched_ff) begin
            len_in     = rx;
            latched_in = 1'b1;
            cur_len    = rx;
            len_bad    = (rx > {2'b00, cfg.max_length});
         end
         if (len_bad) begin
            done = 1'b1;
         end else begin
            if (pos_ff == POS_CMD) begin
               cmd_in = rx;
            end else if (pos_ff == POS_HIGH) begin
               high_in = rx;
            end else if (pos_ff == POS_LOW) begin
               low_in = rx;
            end
            ticks_in = '0;
            pos_in   = pos_ff + POS_W'(1);
            if ((9'(pos_in) >= {1'b0, cur_len} + 9'd3)
                  && rx == rcfp_pkg::TRAILER_BYTE) begin
               fire = 1'b1;
               done = 1'b1;
               priority if (cmd_in == cfg.code_speed) begin
                  speed_in = {high_in, low_in};
               end else if (cmd_in == cfg.code_angle) begin
                  angle_in = {high_in, low_in};
               end else if (cmd_in == cfg.code_pos) begin
                  posn_in = {high_in, low_in};
               end else if (cmd_in == cfg.code_stop) begin
                  speed_in = '0;
                  angle_in = '0;
                  posn_in  = '0;
               end else begin
                  // unknown command, acknowledged only
               end
            end
         end
      end

      if (done) begin
         pos_in     = '0;
         len_in     = '0;
         latched_in = 1'b0;
      end
   end

   always_comb begin
      result.frame_command   = cmd_in;
      result.speed_goal      = $signed(speed_in);
      result.angle_target    = $signed(angle_in);
      result.position_target = $signed(posn_in);
      result.ack             = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         latched_ff <= 1'b0;
         cmd_ff     <= '0;
         high_ff    <= '0;
         low_ff     <= '0;
         ticks_ff   <= '0;
         speed_ff   <= '0;
         angle_ff   <= '0;
         posn_ff    <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         latched_ff <= latched_in;
         cmd_ff     <= cmd_in;
         high_ff    <= high_in;
         low_ff     <= low_in;
         ticks_ff   <= ticks_in;
         speed_ff   <= speed_in;
         angle_ff   <= angle_in;
         posn_ff    <= posn_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/remote_command_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// remote_command_frame_parser_core
// Parses framed remote commands from a byte/tick stream into motion targets.
//
//   channel  dir  payload                                         result
//   req_     in   command, rx_byte                                 -
//   rsp_     out  frame_command, speed_goal, angle/position_target one per frame
//                 and ack
//   csr_     in   reg_index, wr_data                               -
//
// one word per cycle sustained unless a held result stalls intake; a word waits in the
// input register, and its result, if any, is written to the output register as it leaves
// throughput is set by the single parse step between input and output register
// synchronous active-high reset clears parse state, targets and registers
// a held result blocks intake only when the waiting word also completes a frame
// ----------------------------------------------------------------------------
`default_nettype none

module remote_command_frame_parser_core #(
   parameter int BUFFER_BYTES = 40
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rcfp_req_if.sink   req_chan,
   rcfp_rsp_if.source rsp_chan,
   rcfp_csr_if.sink   csr_chan
);

   rcfp_pkg::cfg_type    cfg;
   rcfp_pkg::item_type   stage_item_ff, stage_item_in;
   logic                 stage_valid_ff, stage_valid_in;
   rcfp_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rcfp_pkg::result_type result;
   logic                 fire;
   logic                 advance;
   logic                 req_take;

   rcfp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rcfp_engine #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (stage_item_ff),
      .advance (advance),
      .fire    (fire),
      .result  (result)
   );

   // word leaves the input register unless its result finds the output full and stalled
   assign advance        = stage_valid_ff && (!fire || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (req_take) begin
         stage_valid_in        = 1'b1;
         stage_item_in.command = req_chan.command;
         stage_item_in.rx_byte = req_chan.rx_byte;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.frame_command   = rsp_data_ff.frame_command;
   assign rsp_chan.speed_goal      = rsp_data_ff.speed_goal;
   assign rsp_chan.angle_target    = rsp_data_ff.angle_target;
   assign rsp_chan.position_target = rsp_data_ff.position_target;
   assign rsp_chan.ack             = rsp_data_ff.ack;

endmodule

`default_nettype wire

// ----- hdl/rcfp_checker.sv -----
// ----------------------------------------------------------------------------
// rcfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_frame_command,
   input wire logic [15:0] rsp_speed_goal,
   input wire logic [15:0] rsp_angle_target,
   input wire logic [15:0] rsp_position_target,
   input wire logic        rsp_ack
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_command)
         && $stable(rsp_speed_goal) && $stable(rsp_angle_target)
         && $stable(rsp_position_target))
      else $error("rsp word changed while stalled");

   // intake never waits while the output slot is free or draining
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req stalled with room at the output");

   a_rsp_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ack)
      else $error("rsp word without ack");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // rsp valid never rises straight out of reset; a word passes the input register before any result
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("rsp word right out of reset");

endmodule

bind remote_command_frame_parser_core rcfp_checker u_rcfp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_frame_command   (rsp_chan.frame_command),
   .rsp_speed_goal      (rsp_chan.speed_goal),
   .rsp_angle_target    (rsp_chan.angle_target),
   .rsp_position_target (rsp_chan.position_target),
   .rsp_ack             (rsp_chan.ack)
);

`default_nettype wire
